// ----- design/hbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int IVAL_W   = 12;
  localparam int BPM_W    = 8;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 4;
  localparam int TMO_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W    = 16;

  // divide by five through a scaled reciprocal
  localparam int DIV5_SHIFT = 14;
  localparam logic [2*IVAL_W-1:0] DIV5_RECIP = 24'd3277;

  localparam logic [DIV_W-1:0]    MS_PER_MINUTE  = 16'd60000;
  localparam logic [IVAL_W-1:0]   IVAL_MAX       = 12'd4095;
  localparam logic [BPM_W-1:0]    BPM_MAX        = 8'd255;
  localparam logic [IVAL_W-1:0]   LOST_INTERVAL  = 12'd600;
  localparam logic [IVAL_W-1:0]   RESET_INTERVAL = 12'd750;
  localparam logic [SAMPLE_W-1:0] SEED_AMP       = 12'd100;
  localparam logic [SAMPLE_W-1:0] RESET_LEVEL    = 12'd2048;

  localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 4'd2;
  localparam logic [IVAL_W-1:0]   RST_MIN_GAP       = 12'd250;
  localparam logic [TMO_W-1:0]    RST_TIMEOUT       = 16'd2500;
  localparam logic [SAMPLE_W-1:0] RST_SEED_LEVEL    = 12'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_MIN_GAP       = 2'd1,
    CFG_TIMEOUT       = 2'd2,
    CFG_SEED_LEVEL    = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TIME,
    ST_ELAP,
    ST_EVAL,
    ST_SEED,
    ST_RD,
    ST_UPD,
    ST_MEAN,
    ST_BPM,
    ST_OUT
  } hbd_state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
  } sample_req_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic [BPM_W-1:0]    bpm;
    logic [IVAL_W-1:0]   beat_interval_ms;
    logic                beat_found;
    logic                pulse_high;
    logic [SAMPLE_W-1:0] amplitude;
    logic                lost;
  } result_t;

endpackage

`default_nettype wire

// ----- design/hbd_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hbd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- design/hbd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hbd_pkg::DIV_W-1:0] dividend_i,
  input  logic [hbd_pkg::DIV_W-1:0] divisor_i,
  output logic [hbd_pkg::DIV_W-1:0] quotient_o,
  output logic                      done_o
);
  import hbd_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      if (!trial[DIV_W]) begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ----- design/heart_beat_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// heart beat detector: adaptive-threshold beat detection on pulse-sensor samples
//
// channels: sample_i takes one converter reading per request, cfg_i writes one
// of four registers (sample period, minimum gap, timeout, seed level) by index,
// result_o returns exactly one result per sample (bpm, interval, beat flags,
// amplitude, lost flag). all channels use valid/ready, a request moves when both
// are high. cfg_i is always ready; write it only while the block is idle.
// a sample with no counted beat passes the time, elapsed, evaluate and output
// states after its request is taken; a counted beat adds a history update
// (read and update, after a write to every slot when the second beat seeds the
// history), the mean by a scaled reciprocal and one pass of the serial divider
// for 60000 over the mean. one sample is worked on at a time and the next request
// can be taken in the cycle after the result is loaded.
// a finished result sits in the output register; the next sample is accepted
// while it waits, but that sample's result holds until the receiver takes it.
// reset: registers go to their defaults, detector starts waiting for a first beat;
// the history memory is not cleared since it is always seeded before use.

module heart_beat_detector #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hbd_stream_if.sink   sample_i,
  hbd_stream_if.sink   cfg_i,
  hbd_stream_if.source result_o
);
  import hbd_pkg::*;

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int SUM_W = IVAL_W + $clog2(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(HISTORY_DEPTH - 1);

  // mean over the history by a scaled reciprocal, exact for any 16-bit sum
  localparam int MEAN_SHIFT = DIV_W + $clog2(HISTORY_DEPTH);
  localparam int RECIP_W    = DIV_W + 2;
  localparam int PROD_W     = DIV_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((1 << MEAN_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  // configuration registers
  logic [PERIOD_W-1:0] period_q;
  logic [IVAL_W-1:0]   min_gap_q;
  logic [TMO_W-1:0]    timeout_q;
  logic [SAMPLE_W-1:0] seed_q;

  // detector state
  hbd_state_e          state_q, state_d;
  logic [TIME_W-1:0]   time_now_q, time_now_d;
  logic [TIME_W-1:0]   last_q, last_d;
  logic [TIME_W-1:0]   elapsed_q, elapsed_d;
  logic [SAMPLE_W-1:0] peak_q, peak_d;
  logic [SAMPLE_W-1:0] trough_q, trough_d;
  logic [SAMPLE_W-1:0] thr_q, thr_d;
  logic [SAMPLE_W-1:0] amp_q, amp_d;
  logic [IVAL_W-1:0]   interval_q, interval_d;
  logic [IVAL_W-1:0]   wait_q, wait_d;
  logic [BPM_W-1:0]    bpm_q, bpm_d;
  logic                first_q, first_d;
  logic                second_q, second_d;
  logic                in_pulse_q, in_pulse_d;
  logic                found_q, found_d;
  logic                lost_q, lost_d;
  logic [SAMPLE_W-1:0] sample_q;

  // history bookkeeping
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [PTR_W-1:0]    seed_cnt_q, seed_cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;

  // history memory
  logic [IVAL_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [IVAL_W-1:0]   rd_q;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;

  // output register
  result_t             out_q;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  // serial divider
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quo;
  logic                div_done;

  // history mean
  logic [PROD_W-1:0]   mean_prod;
  logic [IVAL_W-1:0]   mean;

  // evaluation terms
  logic [2*IVAL_W-1:0] div5_prod;
  logic [IVAL_W-3:0]   fifth;
  logic                gt_wait, gt_gap, gt_tmo;
  logic                s_lt_thr, s_gt_thr;
  logic                beat;
  logic [SAMPLE_W-1:0] peak_n, trough_n, amp_n, thr_n;
  logic [IVAL_W-1:0]   ival_sat;

  logic sample_acc;

  assign sample_acc     = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;

  // register writes, unknown codes cannot occur with a two-bit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= RST_SAMPLE_PERIOD;
      min_gap_q <= RST_MIN_GAP;
      timeout_q <= RST_TIMEOUT;
      seed_q    <= RST_SEED_LEVEL;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.payload.index))
        CFG_SAMPLE_PERIOD: period_q  <= cfg_i.payload.data[PERIOD_W-1:0];
        CFG_MIN_GAP:       min_gap_q <= cfg_i.payload.data[IVAL_W-1:0];
        CFG_TIMEOUT:       timeout_q <= cfg_i.payload.data[TMO_W-1:0];
        CFG_SEED_LEVEL:    seed_q    <= cfg_i.payload.data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // wait = (interval / 5) * 3, dicrotic notch hold-off
  assign div5_prod = {{IVAL_W{1'b0}}, interval_q} * DIV5_RECIP;
  assign fifth     = div5_prod[2*IVAL_W-1:DIV5_SHIFT];

  assign mean_prod = PROD_W'(sum_q) * PROD_W'(MEAN_RECIP);
  assign mean      = mean_prod[MEAN_SHIFT +: IVAL_W];

  assign gt_wait  = elapsed_q > TIME_W'(wait_q);
  assign gt_gap   = elapsed_q > TIME_W'(min_gap_q);
  assign gt_tmo   = elapsed_q > TIME_W'(timeout_q);
  assign s_lt_thr = sample_q < thr_q;
  assign s_gt_thr = sample_q > thr_q;

  assign trough_n = (s_lt_thr && gt_wait && (sample_q < trough_q)) ? sample_q : trough_q;
  assign peak_n   = (s_gt_thr && (sample_q > peak_q)) ? sample_q : peak_q;
  assign beat     = gt_gap && s_gt_thr && !in_pulse_q && gt_wait;
  assign ival_sat = (elapsed_q > TIME_W'(IVAL_MAX)) ? IVAL_MAX : elapsed_q[IVAL_W-1:0];

  // threshold goes halfway up the finished beat
  assign amp_n = (peak_n >= trough_n) ? (peak_n - trough_n) : '0;
  assign thr_n = trough_n + (amp_n >> 1);

  always_comb begin
    state_d      = state_q;
    time_now_d   = time_now_q;
    last_d       = last_q;
    elapsed_d    = elapsed_q;
    peak_d       = peak_q;
    trough_d     = trough_q;
    thr_d        = thr_q;
    amp_d        = amp_q;
    interval_d   = interval_q;
    wait_d       = wait_q;
    bpm_d        = bpm_q;
    first_d      = first_q;
    second_d     = second_q;
    in_pulse_d   = in_pulse_q;
    found_d      = found_q;
    lost_d       = lost_q;
    ptr_d        = ptr_q;
    seed_cnt_d   = seed_cnt_q;
    sum_d        = sum_q;
    mem_we       = 1'b0;
    mem_waddr    = ptr_q;
    div_start    = 1'b0;
    div_dividend = MS_PER_MINUTE;
    div_divisor  = div_quo;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (sample_acc) begin
          state_d = ST_TIME;
        end
      end
      ST_TIME: begin
        time_now_d = time_now_q + TIME_W'(period_q);
        wait_d     = IVAL_W'({fifth, 1'b0}) + IVAL_W'(fifth);
        state_d    = ST_ELAP;
      end
      ST_ELAP: begin
        elapsed_d = time_now_q - last_q;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        trough_d = trough_n;
        peak_d   = peak_n;
        found_d  = 1'b0;
        lost_d   = 1'b0;
        state_d  = ST_OUT;
        if (beat) begin
          in_pulse_d = 1'b1;
          interval_d = ival_sat;
          last_d     = time_now_q;
        end
        if (beat && first_q) begin
          // first beat only starts the timing, no other checks
          first_d  = 1'b0;
          second_d = 1'b1;
        end else begin
          if (s_lt_thr && in_pulse_q) begin
            in_pulse_d = 1'b0;
            amp_d      = amp_n;
            thr_d      = thr_n;
            peak_d     = thr_n;
            trough_d   = thr_n;
          end
          if (gt_tmo) begin
            // timeout wins over any beat but the first on the same sample
            thr_d      = seed_q;
            peak_d     = seed_q;
            trough_d   = seed_q;
            last_d     = time_now_q;
            first_d    = 1'b1;
            second_d   = 1'b0;
            bpm_d      = '0;
            interval_d = LOST_INTERVAL;
            in_pulse_d = 1'b0;
            amp_d      = SEED_AMP;
            lost_d     = 1'b1;
          end else if (beat) begin
            found_d = 1'b1;
            if (second_q) begin
              second_d   = 1'b0;
              sum_d      = '0;
              seed_cnt_d = '0;
              state_d    = ST_SEED;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end
      ST_SEED: begin
        // second beat fills every slot with its interval
        mem_we     = 1'b1;
        mem_waddr  = seed_cnt_q;
        sum_d      = sum_q + SUM_W'(interval_q);
        seed_cnt_d = seed_cnt_q + 1'b1;
        if (seed_cnt_q == LAST_IDX) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // oldest slot out, newest interval in
        sum_d     = sum_q - SUM_W'(rd_q) + SUM_W'(interval_q);
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        ptr_d     = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
        state_d   = ST_MEAN;
      end
      ST_MEAN: begin
        if (mean == '0) begin
          bpm_d   = BPM_MAX;
          state_d = ST_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = MS_PER_MINUTE;
          div_divisor  = DIV_W'(mean);
          state_d      = ST_BPM;
        end
      end
      ST_BPM: begin
        if (div_done) begin
          bpm_d   = (div_quo > DIV_W'(BPM_MAX)) ? BPM_MAX : div_quo[BPM_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_now_q  <= '0;
      last_q      <= '0;
      peak_q      <= RESET_LEVEL;
      trough_q    <= RESET_LEVEL;
      thr_q       <= RESET_LEVEL;
      amp_q       <= SEED_AMP;
      interval_q  <= RESET_INTERVAL;
      bpm_q       <= '0;
      first_q     <= 1'b1;
      second_q    <= 1'b0;
      in_pulse_q  <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_now_q  <= time_now_d;
      last_q      <= last_d;
      peak_q      <= peak_d;
      trough_q    <= trough_d;
      thr_q       <= thr_d;
      amp_q       <= amp_d;
      interval_q  <= interval_d;
      bpm_q       <= bpm_d;
      first_q     <= first_d;
      second_q    <= second_d;
      in_pulse_q  <= in_pulse_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-sample working registers
  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      sample_q <= sample_i.payload.sample;
    end
    elapsed_q  <= elapsed_d;
    wait_q     <= wait_d;
    found_q    <= found_d;
    lost_q     <= lost_d;
    seed_cnt_q <= seed_cnt_d;
    sum_q      <= sum_d;
    if (out_load) begin
      out_q.bpm              <= bpm_q;
      out_q.beat_interval_ms <= interval_q;
      out_q.beat_found       <= found_q;
      out_q.pulse_high       <= in_pulse_q;
      out_q.amplitude        <= amp_q;
      out_q.lost             <= lost_q;
    end
  end

  // interval history, at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= interval_q;
    end
    rd_q <= hist_mem[ptr_q];
  end

  hbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

`default_nettype wire

// ----- design/hbd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input hbd_pkg::result_t  out_payload_i
);
  import hbd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i)))
    else $error("result dropped or changed while stalled");

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("sample accepted while another is being worked");

  // timeout beats a beat
  a_found_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_payload_i.beat_found && out_payload_i.lost))
    else $error("beat and timeout reported together");

  // a counted beat leaves the waveform inside the pulse
  a_found_in_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_payload_i.beat_found) |-> out_payload_i.pulse_high)
    else $error("beat reported outside a pulse");

  // timeout restores the defaults
  a_lost_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_payload_i.lost) |->
      (out_payload_i.bpm == '0 && !out_payload_i.pulse_high &&
       out_payload_i.amplitude == SEED_AMP &&
       out_payload_i.beat_interval_ms == LOST_INTERVAL))
    else $error("timeout result without default state");

endmodule

bind heart_beat_detector hbd_checker u_hbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (sample_i.valid),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_payload_i (result_o.payload)
);

`default_nettype wire
